// File: rtl/core/mgs_pkg.sv
// Shared constants and types for the Metropolis Gaussian sampler.
package mgs_pkg;

	// Field widths
	localparam int SAMPLE_W  = 24;
	localparam int SQ_W      = 47;
	localparam int COUNT_W   = 32;
	localparam int UNIF_W    = 16;
	localparam int STEP_W    = 20;
	localparam int BETA_W    = 16;

	// Fixed-point scaling of the sample
	localparam int FRAC_BITS = 16;
	localparam int OFF_SHIFT = 32 - FRAC_BITS;
	localparam int IDX_SHIFT = 2 * FRAC_BITS + 4;

	// Shared multiplier operand width
	localparam int MUL_W     = 33;

	// exp(-1/256) in Q0.32, rounded to nearest
	localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;
	// Exponential table entry zero, 1.0 in Q1.16
	localparam logic [16:0] EXP_ONE      = 17'h10000;

	// Register reset values
	localparam logic [STEP_W-1:0]   STEP_RESET  = 20'd19661;
	localparam logic [BETA_W-1:0]   BETA_RESET  = 16'd1638;
	localparam logic [SAMPLE_W-1:0] START_RESET = 24'd65536;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_STEP_SIZE   = 2'd0,
		REG_INV_TEMP    = 2'd1,
		REG_START_VALUE = 2'd2
	} cfg_reg_t;

endpackage

// File: rtl/core/metropolis_gaussian_sampler_top.sv
// Metropolis Gaussian sampler: sequencer around one shared 33x33 multiplier.
// An item taken on the squares test skips the table states; an item that the
// exponential table decides passes BLO, BHI, BSUM and CMP; a restart adds XSQ.
// Items do not overlap: the multiplier is shared, and a new item is taken only in IDLE.
// Reset: arst_n clears control state, then the table fill runs, during which
// s_tready stays low; configuration writes are taken.
module metropolis_gaussian_sampler_top
	import mgs_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [15:0] proposal_uniform, [31:16] accept_uniform
	input  logic         s_tuser,   // [0] restart
	// Result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [23:0] sample, [70:24] sample_squared,
	                                // [102:71] accept_count, [103] zero
	output logic         m_tuser,   // [0] accepted
	// Configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = $clog2(EXP_TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(EXP_TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		FILL_MUL,
		FILL_RND,
		IDLE,
		XSQ,
		OFF,
		SUM,
		YSQ,
		DIF,
		BLO,
		BHI,
		BSUM,
		CMP,
		DONE
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [STEP_W-1:0]   step_q;
	logic [BETA_W-1:0]   beta_q;
	logic [SAMPLE_W-1:0] start_q;
	logic                cfg_wr;
	cfg_reg_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			beta_q  <= BETA_RESET;
			start_q <= START_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_STEP_SIZE:   step_q  <= pwdata[STEP_W-1:0];
				REG_INV_TEMP:    beta_q  <= pwdata[BETA_W-1:0];
				REG_START_VALUE: start_q <= pwdata[SAMPLE_W-1:0];
				default: ;  // unmapped address: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_STEP_SIZE:   prdata = {12'd0, step_q};
			REG_INV_TEMP:    prdata = {16'd0, beta_q};
			REG_START_VALUE: prdata = {8'd0, start_q};
			default:         prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state and datapath registers
	// ------------------------------------------------------------------
	state_t              state_q;
	logic [AW-1:0]       fill_q;     // table entry being written
	logic [31:0]         r_q;        // exponential recurrence, Q0.32
	logic signed [65:0]  prod_q;     // shared multiplier result
	logic [SAMPLE_W-1:0] x_q;        // current chain sample
	logic [SQ_W-1:0]     x2_q;       // square of current sample
	logic [SAMPLE_W-1:0] y_q;        // proposal
	logic [SQ_W-1:0]     ysq_q;      // square of proposal
	logic [SQ_W-1:0]     d_q;        // positive y^2 - x^2
	logic [47:0]         lo_q;       // beta * d low partial product
	logic [COUNT_W-1:0]  count_q;
	logic [UNIF_W-1:0]   u1_q;
	logic [UNIF_W-1:0]   u2_q;
	logic                rst_q;      // this item restarted the chain
	logic                acc_q;      // accept decision of this item
	logic                out_valid_q;
	logic [103:0]        out_data_q;
	logic                out_flag_q;

	// ------------------------------------------------------------------
	// Shared multiplier: operands chosen by the sequencer state
	// ------------------------------------------------------------------
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [65:0]      mul_p;
	logic [16:0]             u1_off;   // 2*u1 - 65536, signed Q1.16

	assign u1_off = {~u1_q[15], u1_q[14:0], 1'b0};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			FILL_MUL: begin
				mul_a = {1'b0, r_q};
				mul_b = {1'b0, EXP_STEP_Q32};
			end
			XSQ: begin
				mul_a = {{(MUL_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
				mul_b = {{(MUL_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
			end
			OFF: begin
				mul_a = {{(MUL_W-STEP_W){1'b0}}, step_q};
				mul_b = {{(MUL_W-17){u1_off[16]}}, u1_off};
			end
			YSQ: begin
				mul_a = {{(MUL_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q};
				mul_b = {{(MUL_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q};
			end
			BLO: begin
				mul_a = {{(MUL_W-BETA_W){1'b0}}, beta_q};
				mul_b = {1'b0, d_q[31:0]};
			end
			BHI: begin
				mul_a = {{(MUL_W-BETA_W){1'b0}}, beta_q};
				mul_b = {{(MUL_W-15){1'b0}}, d_q[46:32]};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Helper logic between the multiplier register and the sequencer
	// ------------------------------------------------------------------
	logic signed [39:0] off_w;
	logic signed [39:0] ysum_w;
	logic [SAMPLE_W-1:0] y_sat;
	logic signed [47:0] d_w;
	logic               d_le0;
	logic [62:0]        total_w;
	logic [62:0]        idx_full;
	logic [AW-1:0]      rom_raddr;
	logic [32:0]        r_rnd;
	logic [63:0]        r_next;
	logic [16:0]        rom_wdata;
	logic [16:0]        rom_q;
	logic               rom_we;
	logic               tbl_accept;
	logic [COUNT_W-1:0] count_inc;
	logic               out_free;

	localparam logic signed [39:0] Y_MAX = 40'sd8388607;
	localparam logic signed [39:0] Y_MIN = -40'sd8388608;

	// Proposal: x + floor(step * (2u1-1) scaled), clamped to the sample range
	assign off_w  = prod_q[39+OFF_SHIFT:OFF_SHIFT];
	assign ysum_w = off_w + {{(40-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};

	always_comb begin
		priority if (ysum_w > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_W-1:0];
		end else if (ysum_w < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_W-1:0];
		end else begin
			y_sat = ysum_w[SAMPLE_W-1:0];
		end
	end

	// Energy change from the two squares
	assign d_w   = $signed(prod_q[47:0]) - $signed({1'b0, x2_q});
	assign d_le0 = d_w[47] || (d_w == 48'sd0);

	// Table index: beta*d from the two partial products, clamped to the top entry
	assign total_w  = {prod_q[30:0], 32'd0} + {15'd0, lo_q};
	assign idx_full = total_w >> IDX_SHIFT;
	assign rom_raddr = (idx_full > 63'(EXP_TABLE_DEPTH - 1)) ? LAST_IDX : idx_full[AW-1:0];

	assign tbl_accept = rom_q >= {1'b0, u2_q};
	assign count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;

	// Table fill: round the recurrence to Q1.16, advance it by one rounded step
	assign r_rnd     = {1'b0, r_q} + 33'h0_0000_8000;
	assign r_next    = prod_q[63:0] + 64'h0000_0000_8000_0000;
	assign rom_we    = (state_q == FILL_MUL);
	assign rom_wdata = (fill_q == '0) ? EXP_ONE : r_rnd[32:16];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == IDLE);

	// ------------------------------------------------------------------
	// Exponential table memory, registered read
	// ------------------------------------------------------------------
	logic [16:0] rom_mem [EXP_TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (rom_we) begin
			rom_mem[fill_q] <= rom_wdata;
		end
		rom_q <= rom_mem[rom_raddr];
	end

	// ------------------------------------------------------------------
	// Sequencer: state, datapath registers and the result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FILL_MUL;
			fill_q      <= '0;
			r_q         <= EXP_STEP_Q32;
			x_q         <= '0;
			x2_q        <= '0;
			count_q     <= '0;
			rst_q       <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
		end else begin
			// Load a finished item, else drop the result once the downstream side takes it
			if (state_q == DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				FILL_MUL: begin
					// Entry zero is exactly one; later entries come from r_q
					priority if (fill_q == '0) begin
						fill_q <= fill_q + 1'b1;
					end else if (fill_q == LAST_IDX) begin
						state_q <= IDLE;
					end else begin
						prod_q  <= mul_p;
						state_q <= FILL_RND;
					end
				end
				FILL_RND: begin
					r_q     <= r_next[63:32];
					fill_q  <= fill_q + 1'b1;
					state_q <= FILL_MUL;
				end
				IDLE: begin
					if (s_tvalid) begin
						u1_q  <= s_tdata[15:0];
						u2_q  <= s_tdata[31:16];
						rst_q <= s_tuser;
						if (s_tuser) begin
							// Reload the chain before this step
							x_q     <= start_q;
							count_q <= '0;
							state_q <= XSQ;
						end else begin
							state_q <= OFF;
						end
					end
				end
				XSQ: begin
					prod_q  <= mul_p;
					state_q <= OFF;
				end
				OFF: begin
					// Pick up the square of the reloaded start value
					if (rst_q) begin
						x2_q <= prod_q[SQ_W-1:0];
					end
					prod_q  <= mul_p;
					state_q <= SUM;
				end
				SUM: begin
					y_q     <= y_sat;
					state_q <= YSQ;
				end
				YSQ: begin
					prod_q  <= mul_p;
					state_q <= DIF;
				end
				DIF: begin
					if (d_le0) begin
						// Density does not drop: take the proposal
						x_q     <= y_q;
						x2_q    <= prod_q[SQ_W-1:0];
						count_q <= count_inc;
						acc_q   <= 1'b1;
						state_q <= DONE;
					end else begin
						d_q     <= d_w[SQ_W-1:0];
						ysq_q   <= prod_q[SQ_W-1:0];
						state_q <= BLO;
					end
				end
				BLO: begin
					prod_q  <= mul_p;
					state_q <= BHI;
				end
				BHI: begin
					lo_q    <= prod_q[47:0];
					prod_q  <= mul_p;
					state_q <= BSUM;
				end
				BSUM: begin
					// Table read is addressed this cycle, data lands in rom_q
					state_q <= CMP;
				end
				CMP: begin
					acc_q <= tbl_accept;
					if (tbl_accept) begin
						x_q     <= y_q;
						x2_q    <= ysq_q;
						count_q <= count_inc;
					end
					state_q <= DONE;
				end
				DONE: begin
					// Hold until the result register is free
					if (out_free) begin
						out_data_q  <= {1'b0, count_q, x2_q, x_q};
						out_flag_q  <= acc_q;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_flag_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic signed [47:0] x_sq_chk;
	assign x_sq_chk = $signed(x_q) * $signed(x_q);

	// The stored square always tracks the chain sample between items
	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE) |-> (x2_q == x_sq_chk[SQ_W-1:0]))
		else $error("stored square does not match current sample");

	// An accepted request starts the multiply sequence
	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == XSQ || state_q == OFF))
		else $error("accepted request did not start the sequence");

	// A finished item lands in the result register with the current sample
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DONE && out_free) |=> (m_tvalid && m_tdata[23:0] == $past(x_q)))
		else $error("result not loaded from the chain sample");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the Metropolis Gaussian sampler: directed table, then random chains.
`timescale 1ns / 1ps

module tb_top
	import mgs_pkg::*;
();

	localparam int     ROM_DEPTH   = 4096;
	localparam time    CLK_PERIOD  = 12ns;
	localparam longint SAMPLE_HIGH = 8388607;
	localparam longint SAMPLE_LOW  = -8388608;
	localparam int     PHASE_ITEMS = 325;

	// One result as the block presents it
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [SQ_W-1:0]     square;
		logic                accepted;
		logic [COUNT_W-1:0]  count;
	} sample_result_t;

	// One row of the directed table: a register write or a request
	typedef struct {
		bit             is_cfg;
		cfg_reg_t       reg_sel;
		logic [31:0]    value;
		logic           restart;
		logic [15:0]    u1;
		logic [15:0]    u2;
		bit             typed;
		sample_result_t want;
	} plan_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;   // [15:0] proposal_uniform, [31:16] accept_uniform
	logic         s_tuser;   // [0] restart
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;   // [23:0] sample, [70:24] sample_squared, [102:71] accept_count
	logic         m_tuser;   // [0] accepted
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	metropolis_gaussian_sampler_top #(
		.EXP_TABLE_DEPTH(ROM_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: chain position, accept tally and register copies
	longint              chain_x;
	logic [COUNT_W-1:0]  accept_tally;
	logic [STEP_W-1:0]   step_cfg;
	logic [BETA_W-1:0]   beta_cfg;
	logic [SAMPLE_W-1:0] start_cfg;
	logic [16:0]         decay_rom [ROM_DEPTH];

	sample_result_t pending_samples[$];
	plan_row_t      plan[$];
	int             src_idle_pct;
	int             snk_idle_pct;
	int             error_count;
	int             results_seen;
	bit             hold_done;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Generous ceiling on the run: a run that hits it is reported as a failure
	initial begin
		#(CLK_PERIOD * 800000);
		$display("Test completed with failures");
		$finish;
	end

	// Build the exp(-k/256) table in Q1.16 by repeated Q0.32 multiplication
	initial begin : rom_fill
		logic [95:0] ratio;
		ratio = 96'd1 << 32;
		decay_rom[0] = EXP_ONE;
		for (int k = 1; k < ROM_DEPTH; k++) begin
			ratio = (ratio * EXP_STEP_Q32 + (96'd1 << 31)) >> 32;
			decay_rom[k] = 17'((ratio + (96'd1 << 15)) >> 16);
		end
	end

	// Advance the chain by one request and return the result it should produce
	function automatic sample_result_t metropolis_step(input logic restart,
			input logic [15:0] u1, input logic [15:0] u2);
		longint         prop;
		longint         offset;
		longint         y;
		longint         d;
		logic [63:0]    idx;
		logic           took;
		sample_result_t r;
		if (restart) begin
			chain_x = longint'($signed(start_cfg));
			accept_tally = '0;
		end
		// Offset is step * (2*u1 - 1) floored to sample LSBs
		prop = longint'(step_cfg) * (2 * longint'(u1) - 65536);
		offset = prop >>> OFF_SHIFT;
		y = chain_x + offset;
		if (y > SAMPLE_HIGH)
			y = SAMPLE_HIGH;
		if (y < SAMPLE_LOW)
			y = SAMPLE_LOW;
		d = y * y - chain_x * chain_x;
		if (d <= 0) begin
			took = 1'b1;
		end else begin
			idx = (64'(beta_cfg) * 64'(d)) >> IDX_SHIFT;
			if (idx > 64'(ROM_DEPTH - 1))
				idx = 64'(ROM_DEPTH - 1);
			took = decay_rom[idx] >= {1'b0, u2};
		end
		if (took) begin
			chain_x = y;
			if (accept_tally != '1)
				accept_tally = accept_tally + 1'b1;
		end
		r.sample   = chain_x[SAMPLE_W-1:0];
		r.square   = SQ_W'(chain_x * chain_x);
		r.accepted = took;
		r.count    = accept_tally;
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic restart, input logic [15:0] u1,
			input logic [15:0] u2, input bit typed = 1'b0, input sample_result_t want = '0);
		plan_row_t row;
		row = '{is_cfg: 1'b0, reg_sel: REG_STEP_SIZE, value: '0, restart: restart,
			u1: u1, u2: u2, typed: typed, want: want};
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input cfg_reg_t sel, input logic [31:0] value);
		plan_row_t row;
		row = '{is_cfg: 1'b1, reg_sel: sel, value: value, restart: 1'b0,
			u1: '0, u2: '0, typed: 1'b0, want: '0};
		return row;
	endfunction

	// Offer one request, hold it until taken, then queue its expected result
	task automatic send_item(input logic restart, input logic [15:0] u1, input logic [15:0] u2,
			input bit given_ok, input sample_result_t given);
		sample_result_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {u2, u1};
		s_tuser  <= restart;
		do @(posedge clk); while (!s_tready);
		predicted = metropolis_step(restart, u1, u2);
		pending_samples.push_back(given_ok ? given : predicted);
	endtask

	// Drop valid and hold until every queued result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
	endtask

	// Setup phase, access phase, then the bus idles; mirror the value in the predictor
	task automatic cfg_write(input cfg_reg_t sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		unique case (sel)
			REG_STEP_SIZE:   step_cfg  = value[STEP_W-1:0];
			REG_INV_TEMP:    beta_cfg  = value[BETA_W-1:0];
			REG_START_VALUE: start_cfg = value[SAMPLE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic note_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
	endtask

	// Result side: random back-pressure, one long hold-off, compare in order
	initial begin : result_sink
		int             hold_left;
		sample_result_t got;
		sample_result_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.sample   = m_tdata[23:0];
				got.square   = m_tdata[70:24];
				got.count    = m_tdata[102:71];
				got.accepted = m_tuser;
				results_seen++;
				if (pending_samples.size() == 0) begin
					note_mismatch("unexpected result", '0, got.sample);
				end else begin
					want = pending_samples.pop_front();
					if (got.sample !== want.sample)
						note_mismatch("sample", want.sample, got.sample);
					if (got.square !== want.square)
						note_mismatch("sample_squared", want.square, got.square);
					if (got.accepted !== want.accepted)
						note_mismatch("accepted", want.accepted, got.accepted);
					if (got.count !== want.count)
						note_mismatch("accept_count", want.count, got.count);
				end
			end
			// Hold off long enough for the block to back up into its input
			if (results_seen == 300 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Stimulus: reset, directed table, then phases of random chains
	initial begin : stimulus
		logic [31:0] step_val;
		logic [31:0] beta_val;
		logic [31:0] start_val;
		plan_row_t   row;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		chain_x      = 0;
		accept_tally = '0;
		step_cfg     = STEP_RESET;
		beta_cfg     = BETA_RESET;
		start_cfg    = START_RESET;
		error_count  = 0;
		results_seen = 0;
		hold_done    = 1'b0;
		src_idle_pct = 14;
		snk_idle_pct = 82;

		// Directed rows; typed expectations only where obvious
		// Zero offset from reset: stays at zero, accepted
		plan.push_back(item_row(1'b0, 16'd32768, 16'd0, 1'b1, '{24'd0, 47'd0, 1'b1, 32'd1}));
		// Restart to the reset start value with zero offset: equal squares
		plan.push_back(item_row(1'b1, 16'd32768, 16'hFFFF, 1'b1,
			'{24'd65536, 47'h1_0000_0000, 1'b1, 32'd1}));
		plan.push_back(item_row(1'b0, 16'd0, 16'd0));
		plan.push_back(item_row(1'b0, 16'hFFFF, 16'hFFFF));
		plan.push_back(item_row(1'b0, 16'd32767, 16'd40000));
		plan.push_back(item_row(1'b0, 16'd32769, 16'd1));
		plan.push_back(cfg_row(REG_STEP_SIZE, 32'hFFFFF));
		plan.push_back(cfg_row(REG_START_VALUE, 32'h7FFFFF));
		// Proposal past the top of the range saturates back to the start
		plan.push_back(item_row(1'b1, 16'hFFFF, 16'd0, 1'b1,
			'{24'h7FFFFF, 47'd70368727400449, 1'b1, 32'd1}));
		plan.push_back(item_row(1'b0, 16'd0, 16'hFFFF));
		plan.push_back(cfg_row(REG_START_VALUE, 32'h800000));
		// Proposal below the bottom of the range saturates back to the start
		plan.push_back(item_row(1'b1, 16'd0, 16'd0, 1'b1,
			'{24'h800000, 47'h4000_0000_0000, 1'b1, 32'd1}));
		plan.push_back(item_row(1'b0, 16'hFFFF, 16'hFFFF));
		plan.push_back(cfg_row(REG_INV_TEMP, 32'hFFFF));
		plan.push_back(item_row(1'b1, 16'hFFFF, 16'hFFFF));
		plan.push_back(cfg_row(REG_START_VALUE, 32'd0));
		// Huge uphill move: table index saturates, tail entry decides
		plan.push_back(item_row(1'b1, 16'hFFFF, 16'd1));
		plan.push_back(item_row(1'b1, 16'hFFFF, 16'd0));
		plan.push_back(cfg_row(REG_INV_TEMP, 32'd0));
		plan.push_back(item_row(1'b0, 16'hFFFF, 16'hFFFF));
		plan.push_back(cfg_row(REG_STEP_SIZE, 32'd0));
		plan.push_back(item_row(1'b0, 16'd12345, 16'hFFFF));
		plan.push_back(cfg_row(REG_STEP_SIZE, 32'(STEP_RESET)));
		plan.push_back(cfg_row(REG_INV_TEMP, 32'(BETA_RESET)));
		plan.push_back(cfg_row(REG_START_VALUE, 32'(START_RESET)));
		plan.push_back(item_row(1'b1, 16'd50000, 16'd30000));
		plan.push_back(item_row(1'b0, 16'd60000, 16'd65000));
		plan.push_back(item_row(1'b0, 16'd60000, 16'd100));
		plan.push_back(item_row(1'b0, 16'd1000, 16'd32768));
		plan.push_back(item_row(1'b0, 16'd20000, 16'd20000));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg) begin
				wait_drained();
				cfg_write(row.reg_sel, row.value);
			end else begin
				send_item(row.restart, row.u1, row.u2, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < 6; phase++) begin
			// Swap the idling pattern every two phases, last two run flat out
			unique case (phase / 2)
				0: begin src_idle_pct = 14; snk_idle_pct = 82; end
				1: begin src_idle_pct = 82; snk_idle_pct = 14; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			step_val  = (phase == 1) ? 32'hFFFFF : (phase == 4) ? 32'd0
				: $urandom_range(131071);
			beta_val  = (phase == 2) ? 32'hFFFF : (phase == 5) ? 32'd0
				: $urandom_range(65535);
			start_val = (phase == 0) ? 32'h800000 : (phase == 3) ? 32'h7FFFFF
				: 32'($urandom_range(16777215));
			wait_drained();
			cfg_write(REG_STEP_SIZE, step_val);
			cfg_write(REG_INV_TEMP, beta_val);
			cfg_write(REG_START_VALUE, start_val);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Pause mid-chain until the block has emptied out
				if (phase == 3 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_item((n == 0) || ($urandom_range(99) < 4), 16'($urandom),
					16'($urandom), 1'b0, '0);
			end
		end

		wait_drained();
		// Allow a stray extra result to surface
		repeat (30) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/mgs_pkg.sv
rtl/core/metropolis_gaussian_sampler_top.sv
tb/sv/tb_top.sv
